/* src/dtti_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dtti_pkg
// Types, character codes and range limits for the decimal text to integer
// unit.
// ----------------------------------------------------------------------------
package dtti_pkg;

	localparam int CHAR_W  = 8;
	localparam int TYPE_W  = 3;
	localparam int VALUE_W = 64;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

	// largest magnitude that can still be multiplied by ten in 64 bits
	localparam logic [VALUE_W-1:0] MAG_DIV10 = 64'h1999_9999_9999_9999;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TYPE     = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic [TYPE_W-1:0] target_type;
		logic              is_primitive;
		logic              last_char;
	} item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] mag;
		logic               neg;
		status_t            err;
		logic [TYPE_W-1:0]  target_type;
	} token_t;

	// Largest magnitude allowed for a type. Bit 2 selects signed; for signed
	// types a negative token may reach one more than the positive limit.
	function automatic logic [VALUE_W-1:0] type_mag_max(input logic [TYPE_W-1:0] ty,
		input logic neg);
		logic [VALUE_W-1:0] lim;
		lim = '0;
		if (ty[2]) begin
			case (ty[1:0])
				2'd0:    lim = neg ? 64'h80 : 64'h7f;
				2'd1:    lim = neg ? 64'h8000 : 64'h7fff;
				2'd2:    lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
				default: lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
			endcase
		end else begin
			case (ty[1:0])
				2'd0:    lim = 64'hff;
				2'd1:    lim = 64'hffff;
				2'd2:    lim = 64'hffff_ffff;
				default: lim = 64'hffff_ffff_ffff_ffff;
			endcase
		end
		return lim;
	endfunction

endpackage
`default_nettype wire

/* src/decimal_text_to_integer_unit.sv */
// A token's last character passes the input register, the token register and
//   the result register before its result appears.
// Throughput: one character per cycle unless a last character waits on a stall.
// Non-last characters keep flowing while a result waits at the output.
// Reset (arst_n low, asynchronous): pipeline empty, token state cleared.
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_text_to_integer_unit
// Accumulates the decimal magnitude of a numeric token one character at a
// time, with 64-bit overflow checks, and emits a status and the range-checked
// value at the token's last character.
// ----------------------------------------------------------------------------
module decimal_text_to_integer_unit
	import dtti_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [CHAR_W-1:0]  char_code,
	input  wire logic [TYPE_W-1:0]  target_type,
	input  wire logic               is_primitive,
	input  wire logic               last_char,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic [VALUE_W-1:0]      value
);

	item_t              item_s1;
	logic               valid_s1;
	token_t             tok_s2;
	logic               valid_s2;
	logic               out_valid_q;
	status_t            status_q;
	logic [VALUE_W-1:0] value_q;

	logic [VALUE_W-1:0] mag_q;
	logic               neg_q;
	logic               start_q;
	status_t            err_q;

	logic               out_load;
	logic               s2_ready;
	logic               s1_take;

	logic               is_digit;
	logic [3:0]         digit;
	logic [VALUE_W-1:0] mul10;
	logic [VALUE_W:0]   sum;
	logic [VALUE_W-1:0] mag_nx;
	logic               neg_nx;
	status_t            err_nx;

	logic               neg_eff;
	logic [VALUE_W-1:0] limit;
	status_t            fin_status;
	logic [VALUE_W-1:0] fin_value;

	// flow control: stages free as the next takes the item, non-last chars at once
	assign out_load = !out_valid_q || out_ready;
	assign s2_ready = !valid_s2 || out_load;
	assign s1_take  = valid_s1 && (!item_s1.last_char || s2_ready);
	assign in_ready = !valid_s1 || s1_take;

	// character step
	assign is_digit = (item_s1.char_code >= CHAR_ZERO) && (item_s1.char_code <= CHAR_NINE);
	assign digit    = 4'(item_s1.char_code - CHAR_ZERO);
	assign mul10    = {mag_q[VALUE_W-4:0], 3'b000} + {mag_q[VALUE_W-2:0], 1'b0};
	assign sum      = {1'b0, mul10} + {{(VALUE_W-3){1'b0}}, digit};

	always_comb begin
		mag_nx = mag_q;
		neg_nx = neg_q;
		err_nx = err_q;
		if (err_q == ST_OK) begin
			if (!item_s1.is_primitive) begin
				err_nx = ST_TYPE;
			end else if (start_q && item_s1.char_code == CHAR_MINUS
				&& item_s1.target_type[2]) begin
				neg_nx = 1'b1;
			end else if (!is_digit) begin
				err_nx = ST_TYPE;
			end else if (mag_q > MAG_DIV10 || sum[VALUE_W]) begin
				err_nx = ST_OVERFLOW;
			end else begin
				mag_nx = sum[VALUE_W-1:0];
			end
		end
	end

	// range check of a finished token; a minus only counts for signed types
	assign neg_eff = tok_s2.neg && tok_s2.target_type[2];
	assign limit   = type_mag_max(tok_s2.target_type, neg_eff);

	always_comb begin
		fin_status = tok_s2.err;
		fin_value  = '0;
		if (tok_s2.err == ST_OK) begin
			if (tok_s2.mag > limit) begin
				fin_status = ST_OVERFLOW;
			end else begin
				fin_value = neg_eff ? (VALUE_W'(0) - tok_s2.mag) : tok_s2.mag;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			start_q     <= 1'b1;
			err_q       <= ST_OK;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (s1_take) begin
				if (item_s1.last_char) begin
					mag_q   <= '0;
					neg_q   <= 1'b0;
					start_q <= 1'b1;
					err_q   <= ST_OK;
				end else begin
					mag_q   <= mag_nx;
					neg_q   <= neg_nx;
					start_q <= 1'b0;
					err_q   <= err_nx;
				end
			end
			if (s2_ready) begin
				valid_s2 <= s1_take && item_s1.last_char;
			end
			if (out_load) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{char_code: char_code, target_type: target_type,
				is_primitive: is_primitive, last_char: last_char};
		end
		if (s1_take && item_s1.last_char) begin
			tok_s2 <= '{mag: mag_nx, neg: neg_nx, err: err_nx,
				target_type: item_s1.target_type};
		end
		if (out_load && valid_s2) begin
			status_q <= fin_status;
			value_q  <= fin_value;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign value     = value_q;

`ifndef SYNTH
	// a failed token never carries a value
	a_err_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (status_q == ST_OK || value_q == '0))
		else $error("nonzero value with error status");

	// the token state is back at its start after the last character
	a_token_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s1_take && item_s1.last_char |=> start_q && mag_q == '0 && !neg_q
			&& err_q == ST_OK)
		else $error("token state not cleared after last character");

	// the first error of a token holds until its last character
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != ST_OK && !(s1_take && item_s1.last_char) |=> err_q == $past(err_q))
		else $error("token error changed before last character");

	// a held character is not dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_take |=> valid_s1 && $stable(item_s1))
		else $error("stalled character lost");
`endif

endmodule
`default_nettype wire
